// File: rtl/core/bss_pkg.sv
// Shared types, register indexes and constants for the bus switch sequencer.
package bss_pkg;

   localparam int unsigned LevelWidth = 16;
   localparam int unsigned TimeWidth  = 32;
   localparam int unsigned CsrAddrWidth = 3;

   localparam logic [TimeWidth-1:0] RetryTicks = 32'd1000000;

   localparam logic [LevelWidth-1:0] ConnectMinReset = 16'd7000;
   localparam logic [LevelWidth-1:0] PrimaryMaxReset = 16'd7300;
   localparam logic [LevelWidth-1:0] CollapseReset   = 16'd4500;
   localparam logic [LevelWidth-1:0] CodeReset       = 16'd0;

   typedef enum logic [2:0] {
      CMD_NONE       = 3'd0,
      CMD_CLEAR      = 3'd1,
      CMD_CONNECT    = 3'd2,
      CMD_DISCONNECT = 3'd3,
      CMD_ENABLE     = 3'd4,
      CMD_DISABLE    = 3'd5
   } cmd_type;

   typedef enum logic [CsrAddrWidth-1:0] {
      REG_CONNECT_MIN     = 3'd0,
      REG_PRIMARY_MAX     = 3'd1,
      REG_COLLAPSE        = 3'd2,
      REG_CODE_CLEAR      = 3'd3,
      REG_CODE_CONNECT    = 3'd4,
      REG_CODE_DISCONNECT = 3'd5,
      REG_CODE_ENABLE     = 3'd6,
      REG_CODE_DISABLE    = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      REFUSE_NONE        = 2'd0,
      REFUSE_LOCAL_LOW   = 2'd1,
      REFUSE_PRIMARY_HIGH = 2'd2,
      REFUSE_OVERCURRENT = 2'd3
   } refuse_type;

   typedef struct packed {
      logic [TimeWidth-1:0]  now_time;
      logic [LevelWidth-1:0] primary_level;
      logic [LevelWidth-1:0] local_level;
      logic [LevelWidth-1:0] signal_code;
      logic [2:0]            cmd;
   } req_fields_type;

   typedef struct packed {
      refuse_type refuse_reason;
      logic       cmd_accepted;
      logic       retry_active;
      logic       enable_drive;
      logic       connect_drive;
   } rsp_fields_type;

   // True once now has reached the deadline, allowing for wrap of the tick counter.
   function automatic logic time_reached(input logic [TimeWidth-1:0] now,
                                         input logic [TimeWidth-1:0] deadline);
      logic [TimeWidth-1:0] diff;
      diff = now - deadline;
      return ~diff[TimeWidth-1];
   endfunction

endpackage

// File: rtl/core/bus_switch_sequencer.sv
// Bus switch sequencer: command, fault and switch steps of one poll round per request.
// Each request is one complete poll round and is processed combinationally: the
// command, fault and switch steps are evaluated together and their outcome is captured in
// the result register and the sequencer state at the same edge. A new request is taken every
// cycle while the result channel keeps up; the result is registered and shows in the next
// cycle; a waiting result stalls the request channel only if it is not taken in that cycle.
module bus_switch_sequencer
   import bss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request tdata, lowest bit first: cmd[2:0], signal_code[18:3], local_level[34:19],
   // primary_level[50:35], now_time[82:51], zero padding[87:83].
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,
   // Result tdata, lowest bit first: connect_drive[0], enable_drive[1], retry_active[2],
   // cmd_accepted[3], refuse_reason[5:4], zero padding[7:6].
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   input  logic        csr_wen,
   input  logic [CsrAddrWidth-1:0] csr_addr,
   input  logic [LevelWidth-1:0]   csr_wdata
);

   logic [LevelWidth-1:0] connect_min_ff, primary_max_ff, collapse_ff;
   logic [LevelWidth-1:0] code_clear_ff, code_connect_ff, code_disconnect_ff;
   logic [LevelWidth-1:0] code_enable_ff, code_disable_ff;

   logic                  want_connect_ff, want_connect_in;
   logic                  want_enable_ff, want_enable_in;
   logic                  in_retry_ff, in_retry_in;
   logic [TimeWidth-1:0]  deadline_ff, deadline_in;
   logic                  switch_closed_ff, switch_closed_in;

   logic                  rsp_valid_ff;
   rsp_fields_type        rsp_data_ff, rsp_data_in;

   req_fields_type        req;
   logic                  accept;
   logic                  code_ok;
   logic                  accepted;
   logic                  wc_cmd, we_cmd, retry_cmd;
   logic                  fault;
   logic                  retry_flt, closed_flt;
   logic [TimeWidth-1:0]  deadline_flt;
   logic [TimeWidth-1:0]  restart_deadline;
   refuse_type            reason;

   assign req        = req_fields_type'(req_tdata[82:0]);
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};

   assign restart_deadline = req.now_time + RetryTicks;

   always_comb begin
      unique case (req.cmd)
         CMD_CLEAR:      code_ok = (req.signal_code == code_clear_ff);
         CMD_CONNECT:    code_ok = (req.signal_code == code_connect_ff);
         CMD_DISCONNECT: code_ok = (req.signal_code == code_disconnect_ff);
         CMD_ENABLE:     code_ok = (req.signal_code == code_enable_ff);
         CMD_DISABLE:    code_ok = (req.signal_code == code_disable_ff);
         default:        code_ok = 1'b0;
      endcase
      accepted = code_ok;

      wc_cmd    = want_connect_ff;
      we_cmd    = want_enable_ff;
      retry_cmd = in_retry_ff;
      if (accepted) begin
         unique case (req.cmd)
            CMD_CLEAR: begin
               retry_cmd = 1'b0;
            end
            CMD_CONNECT: begin
               if (want_enable_ff) begin
                  wc_cmd = 1'b1;
               end
            end
            CMD_DISCONNECT: begin
               wc_cmd    = 1'b0;
               retry_cmd = 1'b0;
            end
            CMD_ENABLE: begin
               we_cmd = 1'b1;
            end
            default: begin
               we_cmd = 1'b0;
               wc_cmd = 1'b0;
            end
         endcase
      end

      fault        = wc_cmd & (req.local_level < collapse_ff);
      retry_flt    = retry_cmd | fault;
      closed_flt   = (fault & ~retry_cmd) ? 1'b0 : switch_closed_ff;
      deadline_flt = fault ? restart_deadline : deadline_ff;
      reason       = fault ? REFUSE_OVERCURRENT : REFUSE_NONE;

      in_retry_in      = retry_flt;
      deadline_in      = deadline_flt;
      switch_closed_in = closed_flt;
      if (closed_flt != wc_cmd) begin
         if (wc_cmd) begin
            priority if (req.local_level < connect_min_ff) begin
               in_retry_in      = 1'b1;
               deadline_in      = restart_deadline;
               switch_closed_in = 1'b0;
               if (!fault) begin
                  reason = REFUSE_LOCAL_LOW;
               end
            end else if (req.primary_level > primary_max_ff) begin
               in_retry_in      = 1'b1;
               deadline_in      = restart_deadline;
               switch_closed_in = 1'b0;
               if (!fault) begin
                  reason = REFUSE_PRIMARY_HIGH;
               end
            end else if (!retry_flt || time_reached(req.now_time, deadline_flt)) begin
               in_retry_in      = 1'b0;
               switch_closed_in = 1'b1;
            end
         end else begin
            switch_closed_in = 1'b0;
         end
      end

      want_connect_in = wc_cmd;
      want_enable_in  = we_cmd;

      rsp_data_in.connect_drive = switch_closed_in;
      rsp_data_in.enable_drive  = we_cmd;
      rsp_data_in.retry_active  = in_retry_in;
      rsp_data_in.cmd_accepted  = accepted;
      rsp_data_in.refuse_reason = reason;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         connect_min_ff     <= ConnectMinReset;
         primary_max_ff     <= PrimaryMaxReset;
         collapse_ff        <= CollapseReset;
         code_clear_ff      <= CodeReset;
         code_connect_ff    <= CodeReset;
         code_disconnect_ff <= CodeReset;
         code_enable_ff     <= CodeReset;
         code_disable_ff    <= CodeReset;
      end else if (csr_wen) begin
         unique case (reg_index_type'(csr_addr))
            REG_CONNECT_MIN:     connect_min_ff     <= csr_wdata;
            REG_PRIMARY_MAX:     primary_max_ff     <= csr_wdata;
            REG_COLLAPSE:        collapse_ff        <= csr_wdata;
            REG_CODE_CLEAR:      code_clear_ff      <= csr_wdata;
            REG_CODE_CONNECT:    code_connect_ff    <= csr_wdata;
            REG_CODE_DISCONNECT: code_disconnect_ff <= csr_wdata;
            REG_CODE_ENABLE:     code_enable_ff     <= csr_wdata;
            default:             code_disable_ff    <= csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         want_connect_ff  <= 1'b0;
         want_enable_ff   <= 1'b0;
         in_retry_ff      <= 1'b0;
         deadline_ff      <= '0;
         switch_closed_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (accept) begin
            want_connect_ff  <= want_connect_in;
            want_enable_ff   <= want_enable_in;
            in_retry_ff      <= in_retry_in;
            deadline_ff      <= deadline_in;
            switch_closed_ff <= switch_closed_in;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
